// ----- design/dlaa_pkg.sv -----
// Shared types, codes and constants for the dual level alarm unit.
package dlaa_pkg;

   localparam int LEVEL_BITS_DEF = 12;
   localparam int TIMER_BITS_DEF = 16;
   localparam int CSR_IDX_BITS   = 3;

   // Register indexes on the configuration port
   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_THRESHOLD_BIG     = 3'd0,
      REG_THRESHOLD_SMALL   = 3'd1,
      REG_RAISE_DELAY_BIG   = 3'd2,
      REG_RAISE_DELAY_SMALL = 3'd3,
      REG_REPEAT_DELAY_BIG  = 3'd4,
      REG_REPEAT_DELAY_SMALL = 3'd5
   } csr_idx_type;

   // Channel state, one-hot
   typedef enum logic [3:0] {
      MODE_NORMAL  = 4'b0001,
      MODE_PENDING = 4'b0010,
      MODE_ALARM   = 4'b0100,
      MODE_ACKED   = 4'b1000
   } mode_type;

   // Status codes as seen on the result channel
   localparam logic [1:0] STATUS_NORMAL  = 2'd0;
   localparam logic [1:0] STATUS_PENDING = 2'd1;
   localparam logic [1:0] STATUS_ALARM   = 2'd2;
   localparam logic [1:0] STATUS_ACKED   = 2'd3;

   typedef struct packed {
      logic       alarm;
      logic [1:0] status;
   } chan_out_type;

   function automatic logic [1:0] mode_status(input mode_type mode);
      logic [1:0] code;
      unique case (mode)
         MODE_NORMAL:  code = STATUS_NORMAL;
         MODE_PENDING: code = STATUS_PENDING;
         MODE_ALARM:   code = STATUS_ALARM;
         MODE_ACKED:   code = STATUS_ACKED;
         default:      code = STATUS_NORMAL;
      endcase
      return code;
   endfunction

endpackage

// ----- design/dual_level_alarm_with_ack_unit.sv -----
// Dual level alarm with delayed raise, acknowledge and repeat: top level.
//
// Two basin channels each run a four-state alarm (normal, pending, alarm,
// acknowledged) driven by level samples, acknowledge requests and a
// one-second tick carried in each request beat. A beat is taken into an input
// register; once the output register is free, both channels update their
// state and the result lands in the output register on the same edge, so the
// unit sustains one beat per clock while rsp_ready holds. While a finished
// response waits for rsp_ready the request side takes one more beat into the
// input register and then stalls. Configuration writes take effect at once
// and are to be made only while no beat is in flight.
module dual_level_alarm_with_ack_unit import dlaa_pkg::*; #(
   parameter int LEVEL_BITS = LEVEL_BITS_DEF,
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [LEVEL_BITS-1:0]   req_level_big,
   input  logic [LEVEL_BITS-1:0]   req_level_small,
   input  logic                    req_ack_big,
   input  logic                    req_ack_small,
   input  logic                    req_second_tick,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_alarm_big,
   output logic                    rsp_alarm_small,
   output logic [1:0]              rsp_status_big,
   output logic [1:0]              rsp_status_small,
   input  logic                    csr_wen,
   input  logic [CSR_IDX_BITS-1:0] csr_idx,
   input  logic [((LEVEL_BITS > TIMER_BITS) ? LEVEL_BITS : TIMER_BITS)-1:0] csr_wdata
);

   logic [LEVEL_BITS-1:0] thr_big, thr_small;
   logic [TIMER_BITS-1:0] raise_big, raise_small, repeat_big, repeat_small;

   logic                  s1_vld_ff, s1_vld_in;
   logic [LEVEL_BITS-1:0] lvl_big_ff, lvl_small_ff;
   logic                  ack_big_ff, ack_small_ff, tick_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   chan_out_type          big_nxt, small_nxt;
   chan_out_type          big_ff, small_ff;
   logic                  out_free, s1_adv, req_take;

   dlaa_csr #(
      .LEVEL_BITS(LEVEL_BITS),
      .TIMER_BITS(TIMER_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_idx      (csr_idx),
      .csr_wdata    (csr_wdata),
      .thr_big      (thr_big),
      .thr_small    (thr_small),
      .raise_big    (raise_big),
      .raise_small  (raise_small),
      .repeat_big   (repeat_big),
      .repeat_small (repeat_small)
   );

   // Handshake: the output register frees when empty or taken
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign s1_adv       = s1_vld_ff && out_free;
   assign req_ready    = !s1_vld_ff || out_free;
   assign req_take     = req_valid && req_ready;
   assign s1_vld_in    = req_take || (s1_vld_ff && !out_free);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         lvl_big_ff   <= req_level_big;
         lvl_small_ff <= req_level_small;
         ack_big_ff   <= req_ack_big;
         ack_small_ff <= req_ack_small;
         tick_ff      <= req_second_tick;
      end
   end

   dlaa_chan #(
      .LEVEL_BITS(LEVEL_BITS),
      .TIMER_BITS(TIMER_BITS)
   ) u_chan_big (
      .clock        (clock),
      .reset        (reset),
      .upd          (s1_adv),
      .level        (lvl_big_ff),
      .thr          (thr_big),
      .raise_delay  (raise_big),
      .repeat_delay (repeat_big),
      .ack          (ack_big_ff),
      .tick         (tick_ff),
      .nxt          (big_nxt)
   );

   dlaa_chan #(
      .LEVEL_BITS(LEVEL_BITS),
      .TIMER_BITS(TIMER_BITS)
   ) u_chan_small (
      .clock        (clock),
      .reset        (reset),
      .upd          (s1_adv),
      .level        (lvl_small_ff),
      .thr          (thr_small),
      .raise_delay  (raise_small),
      .repeat_delay (repeat_small),
      .ack          (ack_small_ff),
      .tick         (tick_ff),
      .nxt          (small_nxt)
   );

   // Hold the response until taken
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         big_ff   <= big_nxt;
         small_ff <= small_nxt;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_alarm_big    = big_ff.alarm;
   assign rsp_alarm_small  = small_ff.alarm;
   assign rsp_status_big   = big_ff.status;
   assign rsp_status_small = small_ff.status;

`ifndef SYNTHESIS
   // The alarm output is set exactly in the alarm and acknowledged states
   a_alarm_big_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alarm_big ==
         (rsp_status_big == STATUS_ALARM || rsp_status_big == STATUS_ACKED)))
      else $error("big channel alarm flag disagrees with status");

   a_alarm_small_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alarm_small ==
         (rsp_status_small == STATUS_ALARM || rsp_status_small == STATUS_ACKED)))
      else $error("small channel alarm flag disagrees with status");

   // Backpressure only when both the input and output registers are full
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_vld_ff && rsp_valid_ff && !rsp_ready))
      else $error("request stalled with room in the pipeline");

   // An accepted beat yields a response through the input and output registers when the sink stays ready
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && rsp_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("response missing after accepted request");
`endif

endmodule

// ----- design/dlaa_csr.sv -----
// Configuration register bank: thresholds, raise and repeat delays.
module dlaa_csr import dlaa_pkg::*; #(
   parameter int LEVEL_BITS = LEVEL_BITS_DEF,
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wen,
   input  logic [CSR_IDX_BITS-1:0] csr_idx,
   input  logic [((LEVEL_BITS > TIMER_BITS) ? LEVEL_BITS : TIMER_BITS)-1:0] csr_wdata,
   output logic [LEVEL_BITS-1:0]   thr_big,
   output logic [LEVEL_BITS-1:0]   thr_small,
   output logic [TIMER_BITS-1:0]   raise_big,
   output logic [TIMER_BITS-1:0]   raise_small,
   output logic [TIMER_BITS-1:0]   repeat_big,
   output logic [TIMER_BITS-1:0]   repeat_small
);

   logic [LEVEL_BITS-1:0] thr_big_ff, thr_small_ff;
   logic [TIMER_BITS-1:0] raise_big_ff, raise_small_ff;
   logic [TIMER_BITS-1:0] repeat_big_ff, repeat_small_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_big_ff      <= '1;
         thr_small_ff    <= '1;
         raise_big_ff    <= '0;
         raise_small_ff  <= '0;
         repeat_big_ff   <= '0;
         repeat_small_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_idx_type'(csr_idx))
            REG_THRESHOLD_BIG:      thr_big_ff      <= csr_wdata[LEVEL_BITS-1:0];
            REG_THRESHOLD_SMALL:    thr_small_ff    <= csr_wdata[LEVEL_BITS-1:0];
            REG_RAISE_DELAY_BIG:    raise_big_ff    <= csr_wdata[TIMER_BITS-1:0];
            REG_RAISE_DELAY_SMALL:  raise_small_ff  <= csr_wdata[TIMER_BITS-1:0];
            REG_REPEAT_DELAY_BIG:   repeat_big_ff   <= csr_wdata[TIMER_BITS-1:0];
            REG_REPEAT_DELAY_SMALL: repeat_small_ff <= csr_wdata[TIMER_BITS-1:0];
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   assign thr_big      = thr_big_ff;
   assign thr_small    = thr_small_ff;
   assign raise_big    = raise_big_ff;
   assign raise_small  = raise_small_ff;
   assign repeat_big   = repeat_big_ff;
   assign repeat_small = repeat_small_ff;

endmodule

// ----- design/dlaa_chan.sv -----
// One alarm channel: state machine, seconds timer and held acknowledge.
module dlaa_chan import dlaa_pkg::*; #(
   parameter int LEVEL_BITS = LEVEL_BITS_DEF,
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  upd,
   input  logic [LEVEL_BITS-1:0] level,
   input  logic [LEVEL_BITS-1:0] thr,
   input  logic [TIMER_BITS-1:0] raise_delay,
   input  logic [TIMER_BITS-1:0] repeat_delay,
   input  logic                  ack,
   input  logic                  tick,
   output chan_out_type          nxt
);

   mode_type              mode_ff, mode_in;
   logic [TIMER_BITS-1:0] secs_ff, secs_in, secs_cnt;
   logic                  held_ff, held_in, held_eff;
   logic                  flag_ff, flag_in;
   logic                  above, below;

   assign above    = level > thr;
   assign below    = level < thr;
   assign held_eff = held_ff | ack;
   // count a tick, saturating at full scale
   assign secs_cnt = (tick && secs_ff != '1) ? secs_ff + 1'b1 : secs_ff;

   always_comb begin
      mode_in = mode_ff;
      secs_in = secs_ff;
      held_in = held_eff;
      flag_in = flag_ff;
      unique case (mode_ff)
         MODE_NORMAL: begin
            if (above) begin
               mode_in = MODE_PENDING;
               secs_in = '0;
            end
         end
         MODE_PENDING: begin
            secs_in = secs_cnt;
            if (!above) begin
               flag_in = 1'b0;
               mode_in = MODE_NORMAL;
            end else if (secs_cnt >= raise_delay) begin
               flag_in = 1'b1;
               mode_in = MODE_ALARM;
            end
         end
         MODE_ALARM: begin
            if (held_eff) begin
               held_in = 1'b0;
               mode_in = MODE_ACKED;
               secs_in = '0;
            end
         end
         MODE_ACKED: begin
            secs_in = secs_cnt;
            if (below) begin
               flag_in = 1'b0;
               mode_in = MODE_NORMAL;
            end else if (secs_cnt >= repeat_delay) begin
               flag_in = 1'b1;
               mode_in = MODE_ALARM;
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         secs_ff <= '0;
         held_ff <= 1'b0;
         flag_ff <= 1'b0;
      end else if (upd) begin
         mode_ff <= mode_in;
         secs_ff <= secs_in;
         held_ff <= held_in;
         flag_ff <= flag_in;
      end
   end

   assign nxt.alarm  = flag_in;
   assign nxt.status = mode_status(mode_in);

endmodule
